/* design/swcm_pkg.sv */
// -----------------------------------------------------------------------------
// swcm_pkg
// Shared constants and types for the spherical warp coordinate map unit.
// -----------------------------------------------------------------------------
package swcm_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int XY_W           = 12;
    localparam int IDX_W          = 3;
    localparam int REG_W          = 48;

    localparam int DIV1_NUM_W = 41;
    localparam int DIV1_DEN_W = 16;
    localparam int DIV2_NUM_W = 54;
    localparam int DIV2_DEN_W = 33;

    localparam logic [IDX_W-1:0] REG_FOCAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_K1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_K2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROT0  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROT1  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROT2  = 3'd5;
    localparam logic [IDX_W-1:0] REG_SRC   = 3'd6;
    localparam logic [IDX_W-1:0] REG_DST   = 3'd7;

    localparam logic [15:0] FOCAL_RST = 16'd16000;
    localparam logic [47:0] ROT0_RST  = 48'd16384;
    localparam logic [47:0] ROT1_RST  = 48'd1073741824;
    localparam logic [47:0] ROT2_RST  = 48'd70368744177664;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // radians to fraction of a turn, Q32
    localparam logic [29:0] TURN_SCALE = 30'd683565276;

    // odd Taylor coefficients of sin(pi/2 t), Q30, innermost first
    localparam logic [31:0] QS_C [6] = '{
        32'd3864, 32'd172272, 32'd5026995,
        32'd85569306, 32'd693598668, 32'd1686629713
    };

    typedef struct packed {
        logic signed [27:0] px;
        logic signed [27:0] py;
        logic               sat;
        logic               bad;
    } t_carry;

endpackage

/* design/swcm_div.sv */
// -----------------------------------------------------------------------------
// swcm_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// -----------------------------------------------------------------------------
module swcm_div #(
    parameter int NUM_W = swcm_pkg::DIV1_NUM_W,
    parameter int DEN_W = swcm_pkg::DIV1_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_a [NUM_W];
    logic [DEN_W-1:0] r_r [NUM_W];
    logic [DEN_W-1:0] r_d [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] w_ai;
        logic [DEN_W-1:0] w_ri;
        logic [DEN_W-1:0] w_di;
        logic [DEN_W:0]   w_t;
        logic             w_ge;
        logic [NUM_W-1:0] n_a;
        logic [DEN_W-1:0] n_r;

        if (k == 0) begin : g_first
            assign w_ai = i_num;
            assign w_ri = '0;
            assign w_di = i_den;
        end else begin : g_next
            assign w_ai = r_a[k-1];
            assign w_ri = r_r[k-1];
            assign w_di = r_d[k-1];
        end

        assign w_t  = {w_ri, w_ai[NUM_W-1]};
        assign w_ge = (w_t >= {1'b0, w_di});
        assign n_r  = w_ge ? DEN_W'(w_t - {1'b0, w_di}) : w_t[DEN_W-1:0];
        assign n_a  = {w_ai[NUM_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k] <= n_a;
                r_r[k] <= n_r;
                r_d[k] <= w_di;
            end
        end
    end

    assign o_quo = r_a[NUM_W-1];

endmodule

/* design/spherical_warp_coordinate_map_unit.sv */
// -----------------------------------------------------------------------------
// spherical_warp_coordinate_map_unit
// Inverse spherical warp with radial lens distortion: destination pixel in,
// source coordinate (Q24.7) and an invalid flag out.
// -----------------------------------------------------------------------------
// The unit takes one destination pixel per clock and returns its source
// coordinate, one word per clock, while the output is taken. Most of the
// pipeline is the two pipelined dividers: 41 stages for the angle division by
// the focal length and 54 stages for the projection onto the z=1 plane. The
// whole pipeline advances together; it holds only while its output word waits
// to be taken. Write configuration only while no word is in flight.
module spherical_warp_coordinate_map_unit #(
    parameter int COORD_BITS = swcm_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // dst_x, dst_y
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [63:0]                 o_m_axis_tdata,  // src_u, src_v
    output logic                        o_m_axis_tuser,  // invalid
    input  logic                        i_cfg_we,
    input  logic [swcm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [swcm_pkg::REG_W-1:0]  i_cfg_data
);

    localparam int LAT = 1 + swcm_pkg::DIV1_NUM_W + 3 + 7 + 6 + swcm_pkg::DIV2_NUM_W + 13;
    localparam logic [11:0] CMASK =
        (COORD_BITS >= 12) ? 12'hFFF : 12'((1 << COORD_BITS) - 1);
    localparam int D1 = swcm_pkg::DIV1_NUM_W;
    localparam int D2 = swcm_pkg::DIV2_NUM_W;

    function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] v,
                                                   input int unsigned s);
        logic signed [79:0] h;
        h = 80'sd1 <<< (s - 1);
        rnd_shr = (v + h - $signed({79'd0, v[79]})) >>> s;
    endfunction

    // configuration
    logic        [15:0] r_focal;
    logic signed [15:0] r_k1;
    logic signed [15:0] r_k2;
    logic        [47:0] r_rot [3];
    logic        [23:0] r_src;
    logic        [23:0] r_dst;

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    logic [15:0]        w_f;

    // stage 1
    logic        [11:0] w_x, w_y;
    logic signed [13:0] w_dx, w_dy;
    logic        [12:0] w_mx, w_my;
    logic [D1-1:0]      r1_nx, r1_ny;
    logic [1:0]         r1_sg;
    logic [1:0]         r_sg1 [D1];
    logic [D1-1:0]      w_qx1, w_qy1;

    // angles and turn fraction
    logic signed [43:0] r2_a [2];
    logic        [55:0] w_a56 [2];
    logic        [53:0] r3_ml [2];
    logic        [31:0] r3_mh [2];
    logic        [31:0] w_ph [2];
    logic        [1:0]  r4_q [2];
    logic        [30:0] r4_t [4];

    // quarter-wave sine
    logic [61:0] w_qsq [4];
    logic [62:0] w_qm [1:5][4];
    logic [62:0] w_qf [4];
    logic [30:0] r_qs_t  [6][4];
    logic [30:0] r_qs_t2 [5][4];
    logic [31:0] r_qs_p  [1:5][4];
    logic [1:0]  r_qs_q  [7][2];
    logic [31:0] r_qs_s  [4];

    // vector and rotation
    logic signed [31:0] r5_sth, r5_cth, r5_sph, r5_cph;
    logic signed [31:0] w_s [4];
    logic signed [63:0] r6_pa, r6_pc;
    logic signed [31:0] r6_p1;
    logic signed [31:0] r7_p [3];
    logic signed [47:0] r8_m [3][3];
    logic signed [49:0] w_sum [3];
    logic signed [34:0] r9_rp [3];

    // projection
    logic        [33:0] w_m0, w_m1;
    logic [D2-1:0]      r10_nx, r10_ny;
    logic [32:0]        r10_den;
    logic [2:0]         r10_sg;
    logic [2:0]         r_sg2 [D2];
    logic [D2-1:0]      w_qx2, w_qy2;
    logic signed [55:0] w_px, w_py;
    swcm_pkg::t_carry   r_cf [12];

    // distortion and output
    logic        [55:0] r12_sqx, r12_sqy;
    logic        [56:0] w_r2;
    logic        [36:0] r13_r20;
    logic        [30:0] r13_r16;
    logic        [61:0] r14_sq;
    logic signed [53:0] r14_t1, r15_t1, r16_t1;
    logic        [49:0] r15_r4;
    logic signed [66:0] r16_t2;
    logic signed [67:0] r17_fac;
    logic signed [79:0] w_fr;
    logic signed [37:0] r18_fac;
    logic               w_fsat;
    logic signed [65:0] r19_mx, r19_my;
    logic signed [45:0] r20_ux, r20_uy;
    logic signed [62:0] r21_fx, r21_fy;
    logic signed [47:0] r22_u, r22_v;
    logic signed [31:0] r_u, r_v;
    logic               r_inv;

    assign w_en            = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {r_v, r_u};
    assign o_m_axis_tuser  = r_inv;
    assign w_f             = (r_focal == 16'd0) ? 16'd1 : r_focal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= swcm_pkg::FOCAL_RST;
            r_k1    <= '0;
            r_k2    <= '0;
            r_rot[0] <= swcm_pkg::ROT0_RST;
            r_rot[1] <= swcm_pkg::ROT1_RST;
            r_rot[2] <= swcm_pkg::ROT2_RST;
            r_src   <= '0;
            r_dst   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swcm_pkg::REG_FOCAL: r_focal  <= i_cfg_data[15:0];
                swcm_pkg::REG_K1:    r_k1     <= i_cfg_data[15:0];
                swcm_pkg::REG_K2:    r_k2     <= i_cfg_data[15:0];
                swcm_pkg::REG_ROT0:  r_rot[0] <= i_cfg_data;
                swcm_pkg::REG_ROT1:  r_rot[1] <= i_cfg_data;
                swcm_pkg::REG_ROT2:  r_rot[2] <= i_cfg_data;
                swcm_pkg::REG_SRC:   r_src    <= i_cfg_data[23:0];
                swcm_pkg::REG_DST:   r_dst    <= i_cfg_data[23:0];
                default:             r_focal  <= r_focal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // centered pixel, scaled for the angle division
    assign w_x  = i_s_axis_tdata[11:0] & CMASK;
    assign w_y  = i_s_axis_tdata[23:12] & CMASK;
    assign w_dx = $signed({1'b0, w_x, 1'b0}) - $signed({2'b0, r_dst[23:12]});
    assign w_dy = $signed({1'b0, w_y, 1'b0}) - $signed({2'b0, r_dst[11:0]});
    assign w_mx = w_dx[13] ? 13'(-w_dx) : w_dx[12:0];
    assign w_my = w_dy[13] ? 13'(-w_dy) : w_dy[12:0];

    swcm_div #(.NUM_W(D1), .DEN_W(swcm_pkg::DIV1_DEN_W)) u_div_th (
        .i_clk(i_clk), .i_en(w_en), .i_num(r1_nx), .i_den(w_f), .o_quo(w_qx1)
    );
    swcm_div #(.NUM_W(D1), .DEN_W(swcm_pkg::DIV1_DEN_W)) u_div_ph (
        .i_clk(i_clk), .i_en(w_en), .i_num(r1_ny), .i_den(w_f), .o_quo(w_qy1)
    );

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_a56[i] = 56'(r2_a[i]);
            w_ph[i]  = 32'({2'b0, r3_ml[i][53:24]}) + r3_mh[i];
        end
        for (int l = 0; l < 4; l++) begin
            w_qsq[l] = r4_t[l] * r4_t[l];
            w_qm[1][l] = r_qs_t2[0][l] * swcm_pkg::QS_C[0];
            for (int k = 2; k <= 5; k++) begin
                w_qm[k][l] = r_qs_t2[k-1][l] * r_qs_p[k-1][l];
            end
            w_qf[l] = r_qs_t[5][l] * r_qs_p[5][l];
            w_s[l]  = $signed(r_qs_s[l]);
        end
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = 50'(r8_m[i][0]) + 50'(r8_m[i][1]) + 50'(r8_m[i][2]);
        end
    end

    assign w_m0 = r9_rp[0][34] ? 34'(-r9_rp[0]) : r9_rp[0][33:0];
    assign w_m1 = r9_rp[1][34] ? 34'(-r9_rp[1]) : r9_rp[1][33:0];

    swcm_div #(.NUM_W(D2), .DEN_W(swcm_pkg::DIV2_DEN_W)) u_div_px (
        .i_clk(i_clk), .i_en(w_en), .i_num(r10_nx), .i_den(r10_den), .o_quo(w_qx2)
    );
    swcm_div #(.NUM_W(D2), .DEN_W(swcm_pkg::DIV2_DEN_W)) u_div_py (
        .i_clk(i_clk), .i_en(w_en), .i_num(r10_ny), .i_den(r10_den), .o_quo(w_qy2)
    );

    assign w_px = r_sg2[D2-1][2] ? -$signed({2'b0, w_qx2}) : $signed({2'b0, w_qx2});
    assign w_py = r_sg2[D2-1][1] ? -$signed({2'b0, w_qy2}) : $signed({2'b0, w_qy2});
    assign w_r2 = 57'(r12_sqx) + 57'(r12_sqy);
    assign w_fr = rnd_shr(80'(r17_fac), 12);
    assign w_fsat = (w_fr > 80'sd68719476736) || (w_fr < -80'sd68719476736);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_nx <= {w_mx, 28'd0} + D1'(w_f[15:1]);
            r1_ny <= {w_my, 28'd0} + D1'(w_f[15:1]);
            r1_sg <= {w_dx[13], w_dy[13]};
            r_sg1[0] <= r1_sg;
            for (int k = 1; k < D1; k++) begin
                r_sg1[k] <= r_sg1[k-1];
            end

            r2_a[0] <= r_sg1[D1-1][1] ? -$signed({3'b0, w_qx1}) : $signed({3'b0, w_qx1});
            r2_a[1] <= (r_sg1[D1-1][0] ? -$signed({3'b0, w_qy1}) : $signed({3'b0, w_qy1}))
                       - (44'($signed(r_rot[1][47:32])) <<< 10);

            for (int i = 0; i < 2; i++) begin
                r3_ml[i] <= w_a56[i][23:0] * swcm_pkg::TURN_SCALE;
                r3_mh[i] <= 32'(w_a56[i][55:24] * swcm_pkg::TURN_SCALE);
                r4_q[i]  <= w_ph[i][31:30];
                r4_t[2*i]   <= {1'b0, w_ph[i][29:0]};
                r4_t[2*i+1] <= 31'h4000_0000 - {1'b0, w_ph[i][29:0]};
                r_qs_q[0][i] <= r4_q[i];
                for (int k = 1; k < 7; k++) begin
                    r_qs_q[k][i] <= r_qs_q[k-1][i];
                end
            end

            for (int l = 0; l < 4; l++) begin
                r_qs_t[0][l]  <= r4_t[l];
                r_qs_t2[0][l] <= w_qsq[l][60:30];
                for (int k = 1; k < 6; k++) begin
                    r_qs_t[k][l] <= r_qs_t[k-1][l];
                end
                for (int k = 1; k < 5; k++) begin
                    r_qs_t2[k][l] <= r_qs_t2[k-1][l];
                end
                for (int k = 1; k <= 5; k++) begin
                    r_qs_p[k][l] <= swcm_pkg::QS_C[k] - w_qm[k][l][61:30];
                end
                r_qs_s[l] <= w_qf[l][61:30];
            end

            case (r_qs_q[6][0])
                swcm_pkg::QUAD_0: begin r5_sth <= w_s[0];  r5_cth <= w_s[1];  end
                swcm_pkg::QUAD_1: begin r5_sth <= w_s[1];  r5_cth <= -w_s[0]; end
                swcm_pkg::QUAD_2: begin r5_sth <= -w_s[0]; r5_cth <= -w_s[1]; end
                default:          begin r5_sth <= -w_s[1]; r5_cth <= w_s[0];  end
            endcase
            case (r_qs_q[6][1])
                swcm_pkg::QUAD_0: begin r5_sph <= w_s[2];  r5_cph <= w_s[3];  end
                swcm_pkg::QUAD_1: begin r5_sph <= w_s[3];  r5_cph <= -w_s[2]; end
                swcm_pkg::QUAD_2: begin r5_sph <= -w_s[2]; r5_cph <= -w_s[3]; end
                default:          begin r5_sph <= -w_s[3]; r5_cph <= w_s[2];  end
            endcase

            r6_pa <= r5_sth * r5_cph;
            r6_pc <= r5_cth * r5_cph;
            r6_p1 <= r5_sph;
            r7_p[0] <= 32'(rnd_shr(80'(r6_pa), 30));
            r7_p[1] <= r6_p1;
            r7_p[2] <= 32'(rnd_shr(80'(r6_pc), 30));
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r8_m[i][j] <= $signed(r_rot[i][16*j +: 16]) * r7_p[j];
                end
                r9_rp[i] <= 35'(rnd_shr(80'(w_sum[i]), 14));
            end

            r10_nx  <= {w_m0, 20'd0} + D2'(r9_rp[2][32:1]);
            r10_ny  <= {w_m1, 20'd0} + D2'(r9_rp[2][32:1]);
            r10_den <= r9_rp[2][32:0];
            r10_sg  <= {r9_rp[0][34], r9_rp[1][34], (r9_rp[2] <= 35'sd0)};
            r_sg2[0] <= r10_sg;
            for (int k = 1; k < D2; k++) begin
                r_sg2[k] <= r_sg2[k-1];
            end

            r_cf[0].bad <= r_sg2[D2-1][0];
            r_cf[0].sat <= (w_px > 56'sd67108864) || (w_px < -56'sd67108864)
                        || (w_py > 56'sd67108864) || (w_py < -56'sd67108864);
            r_cf[0].px <= (w_px > 56'sd67108864) ? 28'sd67108864 :
                          (w_px < -56'sd67108864) ? -28'sd67108864 : 28'(w_px);
            r_cf[0].py <= (w_py > 56'sd67108864) ? 28'sd67108864 :
                          (w_py < -56'sd67108864) ? -28'sd67108864 : 28'(w_py);
            for (int k = 1; k < 12; k++) begin
                if (k != 7) begin
                    r_cf[k] <= r_cf[k-1];
                end
            end
            r_cf[7] <= {r_cf[6].px, r_cf[6].py, r_cf[6].sat | w_fsat, r_cf[6].bad};

            r12_sqx <= r_cf[0].px * r_cf[0].px;
            r12_sqy <= r_cf[0].py * r_cf[0].py;
            r13_r20 <= 37'((w_r2 + 57'd524288) >> 20);
            r13_r16 <= 31'((w_r2 + 57'd8388608) >> 24);
            r14_sq  <= r13_r16 * r13_r16;
            r14_t1  <= r_k1 * $signed({1'b0, r13_r20});
            r15_r4  <= 50'((r14_sq + 62'd2048) >> 12);
            r15_t1  <= r14_t1;
            r16_t2  <= r_k2 * $signed({1'b0, r15_r4});
            r16_t1  <= r15_t1;
            r17_fac <= 68'sh1_0000_0000 + 68'(r16_t1) + 68'(r16_t2);
            r18_fac <= (w_fr > 80'sd68719476736) ? 38'sd68719476736 :
                       (w_fr < -80'sd68719476736) ? -38'sd68719476736 : 38'(w_fr);

            r19_mx <= r_cf[7].px * r18_fac;
            r19_my <= r_cf[7].py * r18_fac;
            r20_ux <= 46'(rnd_shr(80'(r19_mx), 20));
            r20_uy <= 46'(rnd_shr(80'(r19_my), 20));
            r21_fx <= r20_ux * $signed({1'b0, w_f});
            r21_fy <= r20_uy * $signed({1'b0, w_f});
            r22_u  <= 48'(rnd_shr(80'(r21_fx), 17)) + $signed({29'd0, r_src[23:12], 7'd0});
            r22_v  <= 48'(rnd_shr(80'(r21_fy), 17)) + $signed({29'd0, r_src[11:0], 7'd0});

            if (r_cf[11].bad) begin
                r_u   <= '0;
                r_v   <= '0;
                r_inv <= 1'b1;
            end else begin
                r_u <= (r22_u > 48'sd2147483647) ? 32'sd2147483647 :
                       (r22_u < -48'sd2147483647) ? -32'sd2147483647 : 32'(r22_u);
                r_v <= (r22_v > 48'sd2147483647) ? 32'sd2147483647 :
                       (r22_v < -48'sd2147483647) ? -32'sd2147483647 : 32'(r22_v);
                r_inv <= r_cf[11].sat
                      || (r22_u > 48'sd2147483647) || (r22_u < -48'sd2147483647)
                      || (r22_v > 48'sd2147483647) || (r22_v < -48'sd2147483647);
            end
        end
    end

endmodule
